/* src/chm_pkg.sv */
// Shared constants and types of the compact hash map engine.
package chm_pkg;

  localparam int INDEX_SIZE    = 1024;
  localparam int SLOT_COUNT    = 512;
  localparam int KEY_BITS      = 32;
  localparam int VALUE_BITS    = 32;
  localparam int HASH_BITS     = 32;
  localparam int PERTURB_SHIFT = 5;

  localparam int IDX_W  = $clog2(INDEX_SIZE);
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int STEP_W = $clog2(INDEX_SIZE + 1);
  localparam int MARK_W = 2;
  localparam int IENT_W = MARK_W + SLOT_W;
  localparam int SENT_W = HASH_BITS + KEY_BITS + VALUE_BITS;

  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_LIVE    = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [MARK_W-1:0] mark;
    logic [SLOT_W-1:0] slot;
  } ient_t;

  typedef struct packed {
    logic [HASH_BITS-1:0]  hash;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } sent_t;

endpackage

/* src/chm_ram.sv */
// Generic single-port RAM with registered read.
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/compact_hash_map_engine.sv */
// Top level of the compact hash map engine: probe sequencer over index and slot memories.
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall   | opcode, key_hash, key, value
//  out_    | output    | out_valid/out_stall | status, key, value, entry_count
//
// Each probe step reads the index memory (S_P_IDX, S_P_EVAL), plus S_P_CMP when a live
// entry's slot is compared; a probed item then passes S_UPD and S_FIN (a remove that
// moves the last slot probes twice). The single index memory port sets the pace.
// Reset and clear both sweep every index memory entry; no item is taken meanwhile.
// A finished result waits in the output register while the next item is taken.
module compact_hash_map_engine
  import chm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic [HASH_BITS-1:0]  in_key_hash,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [KEY_BITS-1:0]   out_key,
  output logic [VALUE_BITS-1:0] out_value,
  output logic [CNT_W-1:0]      out_entry_count
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_CLR     = 10'b0000000010,
    S_P_IDX   = 10'b0000000100,
    S_P_EVAL  = 10'b0000001000,
    S_P_CMP   = 10'b0000010000,
    S_UPD     = 10'b0000100000,
    S_RM_RD   = 10'b0001000000,
    S_RM_LAST = 10'b0010000000,
    S_FIN     = 10'b0100000000,
    S_SPARE   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]            op_r, op_nxt;
  logic [HASH_BITS-1:0]  ph_r, ph_nxt;
  logic [KEY_BITS-1:0]   pk_r, pk_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [HASH_BITS-1:0]  perturb_r, perturb_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [SLOT_W-1:0]     s_r, s_nxt;
  logic [SLOT_W-1:0]     hole_r, hole_nxt;
  logic                  hf_r, hf_nxt;
  logic [IDX_W-1:0]      fpos_r, fpos_nxt;
  sent_t                 last_r, last_nxt;
  logic                  phase2_r, phase2_nxt;
  logic [CNT_W-1:0]      live_r, live_nxt;
  logic [IDX_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic                  report_r, report_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [KEY_BITS-1:0]   rkey_r, rkey_nxt;
  logic [VALUE_BITS-1:0] rval_r, rval_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [1:0]            ostatus_r, ostatus_nxt;
  logic [KEY_BITS-1:0]   okey_r, okey_nxt;
  logic [VALUE_BITS-1:0] oval_r, oval_nxt;
  logic [CNT_W-1:0]      ocnt_r, ocnt_nxt;

  logic              iwe;
  logic [IDX_W-1:0]  iaddr;
  ient_t             iwdata, irdata;
  logic              swe;
  logic [SLOT_W-1:0] saddr;
  sent_t             swdata, srdata;

  logic [HASH_BITS-1:0] pshift;
  logic [IDX_W-1:0]     idx_adv;
  logic [SLOT_W-1:0]    last_slot;

  chm_ram #(.WIDTH(IENT_W), .DEPTH(INDEX_SIZE)) u_index (
    .clk(clk), .we(iwe), .addr(iaddr), .wdata(iwdata), .rdata(irdata)
  );

  chm_ram #(.WIDTH(SENT_W), .DEPTH(SLOT_COUNT)) u_slots (
    .clk(clk), .we(swe), .addr(saddr), .wdata(swdata), .rdata(srdata)
  );

  assign pshift    = perturb_r >> PERTURB_SHIFT;
  assign idx_adv   = IDX_W'({idx_r, 2'b00}) + idx_r + pshift[IDX_W-1:0] + IDX_W'(1);
  assign last_slot = SLOT_W'(live_r - CNT_W'(1));

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = ovalid_r;
  assign out_status      = ostatus_r;
  assign out_key         = okey_r;
  assign out_value       = oval_r;
  assign out_entry_count = ocnt_r;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    ph_nxt       = ph_r;
    pk_nxt       = pk_r;
    val_nxt      = val_r;
    perturb_nxt  = perturb_r;
    idx_nxt      = idx_r;
    step_nxt     = step_r;
    found_nxt    = found_r;
    pos_nxt      = pos_r;
    s_nxt        = s_r;
    hole_nxt     = hole_r;
    hf_nxt       = hf_r;
    fpos_nxt     = fpos_r;
    last_nxt     = last_r;
    phase2_nxt   = phase2_r;
    live_nxt     = live_r;
    clr_addr_nxt = clr_addr_r;
    report_nxt   = report_r;
    st_nxt       = st_r;
    rkey_nxt     = rkey_r;
    rval_nxt     = rval_r;
    ovalid_nxt   = ovalid_r && out_stall;
    ostatus_nxt  = ostatus_r;
    okey_nxt     = okey_r;
    oval_nxt     = oval_r;
    ocnt_nxt     = ocnt_r;

    iwe    = 1'b0;
    iaddr  = idx_r;
    iwdata = '0;
    swe    = 1'b0;
    saddr  = s_r;
    swdata = '{hash: ph_r, key: pk_r, value: val_r};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_opcode;
          ph_nxt      = in_key_hash;
          pk_nxt      = in_key;
          val_nxt     = in_value;
          perturb_nxt = in_key_hash;
          idx_nxt     = in_key_hash[IDX_W-1:0];
          step_nxt    = '0;
          found_nxt   = 1'b0;
          hf_nxt      = 1'b0;
          phase2_nxt  = 1'b0;
          st_nxt      = ST_OK;
          rkey_nxt    = '0;
          rval_nxt    = '0;
          case (in_opcode)
            OP_CLEAR: begin
              clr_addr_nxt = '0;
              report_nxt   = 1'b1;
              state_nxt    = S_CLR;
            end
            OP_SET: state_nxt = S_P_IDX;
            default: begin
              if (live_r == '0) begin
                st_nxt    = ST_MISS;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_P_IDX;
              end
            end
          endcase
        end
      end
      S_CLR: begin
        iwe          = 1'b1;
        iaddr        = clr_addr_r;
        iwdata       = '0;
        clr_addr_nxt = clr_addr_r + IDX_W'(1);
        if (clr_addr_r == IDX_W'(INDEX_SIZE - 1)) begin
          live_nxt  = '0;
          st_nxt    = ST_OK;
          state_nxt = report_r ? S_FIN : S_IDLE;
        end
      end
      S_P_IDX: begin
        state_nxt = S_P_EVAL;
      end
      S_P_EVAL: begin
        if (irdata.mark == MARK_EMPTY) begin
          if (!hf_r) begin
            hf_nxt   = 1'b1;
            fpos_nxt = idx_r;
          end
          state_nxt = S_UPD;
        end else if (irdata.mark != MARK_DELETED &&
                     {1'b0, irdata.slot} < live_r) begin
          saddr     = irdata.slot;
          s_nxt     = irdata.slot;
          state_nxt = S_P_CMP;
        end else begin
          if (irdata.mark == MARK_DELETED && !hf_r) begin
            hf_nxt   = 1'b1;
            fpos_nxt = idx_r;
          end
          step_nxt = step_r + STEP_W'(1);
          if (step_r == STEP_W'(INDEX_SIZE - 1)) begin
            state_nxt = S_UPD;
          end else begin
            perturb_nxt = pshift;
            idx_nxt     = idx_adv;
            state_nxt   = S_P_IDX;
          end
        end
      end
      S_P_CMP: begin
        if (srdata.hash == ph_r && srdata.key == pk_r) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
          rkey_nxt  = srdata.key;
          rval_nxt  = srdata.value;
          state_nxt = S_UPD;
        end else begin
          step_nxt = step_r + STEP_W'(1);
          if (step_r == STEP_W'(INDEX_SIZE - 1)) begin
            state_nxt = S_UPD;
          end else begin
            perturb_nxt = pshift;
            idx_nxt     = idx_adv;
            state_nxt   = S_P_IDX;
          end
        end
      end
      S_UPD: begin
        state_nxt = S_FIN;
        case (op_r)
          OP_GET: begin
            if (!found_r) begin
              st_nxt   = ST_MISS;
              rkey_nxt = '0;
              rval_nxt = '0;
            end
          end
          OP_SET: begin
            rkey_nxt = '0;
            rval_nxt = '0;
            if (found_r) begin
              swe   = 1'b1;
              saddr = s_r;
            end else if (live_r >= CNT_W'(SLOT_COUNT) || !hf_r) begin
              st_nxt = ST_FULL;
            end else begin
              swe      = 1'b1;
              saddr    = SLOT_W'(live_r);
              iwe      = 1'b1;
              iaddr    = fpos_r;
              iwdata   = '{mark: MARK_LIVE, slot: SLOT_W'(live_r)};
              live_nxt = live_r + CNT_W'(1);
            end
          end
          OP_REMOVE: begin
            rkey_nxt = '0;
            rval_nxt = '0;
            if (phase2_r) begin
              if (found_r) begin
                iwe    = 1'b1;
                iaddr  = pos_r;
                iwdata = '{mark: MARK_LIVE, slot: hole_r};
              end
              swe      = 1'b1;
              saddr    = hole_r;
              swdata   = last_r;
              live_nxt = live_r - CNT_W'(1);
            end else if (!found_r) begin
              st_nxt = ST_MISS;
            end else begin
              iwe    = 1'b1;
              iaddr  = pos_r;
              iwdata = '{mark: MARK_DELETED, slot: '0};
              if (s_r != last_slot) begin
                hole_nxt  = s_r;
                state_nxt = S_RM_RD;
              end else begin
                live_nxt = live_r - CNT_W'(1);
              end
            end
          end
          default: ;
        endcase
      end
      S_RM_RD: begin
        saddr     = last_slot;
        state_nxt = S_RM_LAST;
      end
      S_RM_LAST: begin
        last_nxt    = srdata;
        ph_nxt      = srdata.hash;
        pk_nxt      = srdata.key;
        perturb_nxt = srdata.hash;
        idx_nxt     = srdata.hash[IDX_W-1:0];
        step_nxt    = '0;
        found_nxt   = 1'b0;
        phase2_nxt  = 1'b1;
        state_nxt   = S_P_IDX;
      end
      S_FIN: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = st_r;
          okey_nxt    = rkey_r;
          oval_nxt    = rval_r;
          ocnt_nxt    = live_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_addr_r <= '0;
      report_r   <= 1'b0;
      live_r     <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      report_r   <= report_nxt;
      live_r     <= live_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ph_r      <= ph_nxt;
    pk_r      <= pk_nxt;
    val_r     <= val_nxt;
    perturb_r <= perturb_nxt;
    idx_r     <= idx_nxt;
    step_r    <= step_nxt;
    found_r   <= found_nxt;
    pos_r     <= pos_nxt;
    s_r       <= s_nxt;
    hole_r    <= hole_nxt;
    hf_r      <= hf_nxt;
    fpos_r    <= fpos_nxt;
    last_r    <= last_nxt;
    phase2_r  <= phase2_nxt;
    st_r      <= st_nxt;
    rkey_r    <= rkey_nxt;
    rval_r    <= rval_nxt;
    ostatus_r <= ostatus_nxt;
    okey_r    <= okey_nxt;
    oval_r    <= oval_nxt;
    ocnt_r    <= ocnt_nxt;
  end

endmodule

/* bench/tb_top.sv */
// Testbench for the compact hash map engine: random and directed map operations.
`timescale 1ns / 1ps

class map_scoreboard;
  typedef struct {
    logic [1:0]  status;
    logic [31:0] key;
    logic [31:0] value;
    logic [9:0]  count;
  } map_result_t;

  logic [1:0]  idx_mark [1024];
  int unsigned idx_slot [1024];
  logic [31:0] s_hash [512];
  logic [31:0] s_key [512];
  logic [31:0] s_val [512];
  int unsigned live;
  map_result_t pending[$];
  int errors;
  int mism;

  function new();
    foreach (idx_mark[i]) begin
      idx_mark[i] = chm_pkg::MARK_EMPTY;
      idx_slot[i] = 0;
    end
    live = 0;
    errors = 0;
    mism = 0;
  endfunction

  function bit find_key(logic [31:0] h, logic [31:0] k, output int unsigned pos,
                        output int unsigned fpos, output bit hf);
    logic [31:0] pert;
    int unsigned i;
    pert = h;
    i = h % 1024;
    hf = 0;
    fpos = 0;
    pos = 0;
    for (int st = 0; st < 1024; st++) begin
      if (idx_mark[i] == chm_pkg::MARK_EMPTY) begin
        if (!hf) begin
          fpos = i;
          hf = 1;
        end
        return 0;
      end
      if (idx_mark[i] == chm_pkg::MARK_DELETED) begin
        if (!hf) begin
          fpos = i;
          hf = 1;
        end
      end else if (idx_slot[i] < live && s_hash[idx_slot[i]] == h &&
                   s_key[idx_slot[i]] == k) begin
        pos = i;
        return 1;
      end
      pert = pert >> chm_pkg::PERTURB_SHIFT;
      i = (64'(i) * 5 + pert + 1) % 1024;
    end
    return 0;
  endfunction

  function void note_item(logic [1:0] op, logic [31:0] h, logic [31:0] k, logic [31:0] v);
    map_result_t r;
    int unsigned pos, fpos, lpos, s, last;
    bit hf, found;
    r.status = chm_pkg::ST_OK;
    r.key = 0;
    r.value = 0;
    case (op)
      chm_pkg::OP_GET: begin
        if (live != 0 && find_key(h, k, pos, fpos, hf)) begin
          r.key = s_key[idx_slot[pos]];
          r.value = s_val[idx_slot[pos]];
        end else r.status = chm_pkg::ST_MISS;
      end
      chm_pkg::OP_SET: begin
        found = find_key(h, k, pos, fpos, hf);
        if (found) s_val[idx_slot[pos]] = v;
        else if (live >= 512 || !hf) r.status = chm_pkg::ST_FULL;
        else begin
          s_hash[live] = h;
          s_key[live] = k;
          s_val[live] = v;
          idx_mark[fpos] = chm_pkg::MARK_LIVE;
          idx_slot[fpos] = live;
          live++;
        end
      end
      chm_pkg::OP_REMOVE: begin
        if (live != 0 && find_key(h, k, pos, fpos, hf)) begin
          s = idx_slot[pos];
          last = live - 1;
          idx_mark[pos] = chm_pkg::MARK_DELETED;
          idx_slot[pos] = 0;
          if (s != last) begin
            if (find_key(s_hash[last], s_key[last], lpos, fpos, hf)) idx_slot[lpos] = s;
            s_hash[s] = s_hash[last];
            s_key[s] = s_key[last];
            s_val[s] = s_val[last];
          end
          live = last;
        end else r.status = chm_pkg::ST_MISS;
      end
      default: begin
        foreach (idx_mark[i]) begin
          idx_mark[i] = chm_pkg::MARK_EMPTY;
          idx_slot[i] = 0;
        end
        live = 0;
      end
    endcase
    r.count = 10'(live);
    pending.push_back(r);
  endfunction

  function void check_result(logic [1:0] st, logic [31:0] k, logic [31:0] v, logic [9:0] c);
    map_result_t e;
    if (pending.size() == 0) begin
      errors++;
      if (mism++ < 10) $display("unexpected result: st=%0d key=%h val=%h cnt=%0d", st, k, v, c);
      return;
    end
    e = pending.pop_front();
    if (st !== e.status || k !== e.key || v !== e.value || c !== e.count) begin
      errors++;
      if (mism++ < 10)
        $display({"mismatch: exp st=%0d key=%h val=%h cnt=%0d, ",
                  "got st=%0d key=%h val=%h cnt=%0d"},
                 e.status, e.key, e.value, e.count, st, k, v, c);
    end
  endfunction
endclass

module tb_top;
  import chm_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_opcode = 0;
  logic [31:0] in_key_hash = 0;
  logic [31:0] in_key = 0;
  logic [31:0] in_value = 0;
  logic out_valid;
  logic out_stall = 1;
  logic [1:0] out_status;
  logic [31:0] out_key;
  logic [31:0] out_value;
  logic [CNT_W-1:0] out_entry_count;

  map_scoreboard sb = new();
  int unsigned cycles = 0;
  bit quiet = 0;
  bit hold_off = 0;
  logic [31:0] pool_key [64];
  logic [31:0] pool_hash [64];

  always #2 clk = ~clk;

  compact_hash_map_engine dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_key, out_value, out_entry_count);
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1;
    else out_stall <= hold_off || (!quiet && $urandom_range(99) < 6);
  end

  task automatic send(logic [1:0] op, logic [31:0] h, logic [31:0] k, logic [31:0] v);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_key_hash <= h;
    in_key <= k;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, h, k, v);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic rand_item();
    int j;
    int r;
    j = $urandom_range(63);
    r = $urandom_range(99);
    if (r < 5) send($urandom, $urandom, $urandom, $urandom);
    else if (r < 45) send(OP_SET, pool_hash[j], pool_key[j], $urandom);
    else if (r < 75) send(OP_GET, pool_hash[j], pool_key[j], $urandom);
    else if (r < 97) send(OP_REMOVE, pool_hash[j], pool_key[j], $urandom);
    else send(OP_CLEAR, $urandom, $urandom, $urandom);
  endtask

  initial begin
    foreach (pool_key[i]) begin
      pool_key[i] = $urandom;
      pool_hash[i] = (i < 16) ? {2'($urandom_range(3)), 30'd5} : $urandom;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1;
    // empty map, extremes, replace, collisions, same hash different key
    send(OP_GET, 0, 0, 0);
    send(OP_REMOVE, 32'hffffffff, 32'hffffffff, 0);
    send(OP_SET, 0, 0, 32'hffffffff);
    send(OP_SET, 32'hffffffff, 32'hffffffff, 32'h0);
    send(OP_GET, 0, 0, 0);
    send(OP_GET, 32'hffffffff, 32'hffffffff, 0);
    send(OP_SET, 0, 0, 32'h12345678);
    send(OP_SET, 0, 1, 32'haaaaaaaa);
    send(OP_SET, 1024, 2, 32'h55555555);
    send(OP_GET, 0, 1, 0);
    send(OP_GET, 1024, 3, 0);
    send(OP_REMOVE, 0, 0, 0);
    send(OP_GET, 1024, 2, 0);
    send(OP_SET, 0, 7, 1);
    send(OP_REMOVE, 0, 0, 0);
    send(OP_CLEAR, 0, 0, 0);
    send(OP_GET, 0, 1, 0);
    send(OP_REMOVE, 0, 1, 0);
    drain();
    // fill to full
    for (int i = 0; i < 514; i++) send(OP_SET, $urandom, i, i);
    send(OP_SET, 0, 32'hdeadbeef, 0);
    send(OP_GET, 0, 32'hdeadbeef, 0);
    for (int i = 0; i < 20; i++) send(OP_REMOVE, 0, i, 0);
    send(OP_CLEAR, 0, 0, 0);
    // receiver holds off while sender keeps going
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 60; i++) rand_item();
    join
    drain();
    quiet = 1;
    for (int i = 0; i < 100; i++) rand_item();
    quiet = 0;
    for (int i = 0; i < 100; i++) rand_item();
    drain();
    repeat (2000) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
